// ----- src/rsk_pkg.sv -----
package rsk_pkg;

    localparam int CAPACITY = 64;
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int SORT_W   = $clog2(CAPACITY);

    localparam logic signed [16:0] NULL_CODE = -17'sd1;

    localparam int KEY_STATION = 0;
    localparam int KEY_NEXT    = 1;

    typedef struct packed {
        logic [15:0]        station_code;
        logic signed [16:0] next_station_code;
        logic [31:0]        record_tag;
    } rec_t;

    typedef struct packed {
        logic valid;
        rec_t rec;
    } cell_t;

    typedef struct packed {
        logic shift;
        logic lo_en;
        logic hi_en;
        logic key;
    } cell_ctrl_t;

    localparam cell_t EMPTY_CELL = '0;

    // Empty cells sort after every record; by next code, nulls go after every real code.
    function automatic logic goes_before(cell_t x, cell_t y, logic key);
        logic x_null;
        logic y_null;
        logic res;
        x_null = (x.rec.next_station_code == NULL_CODE);
        y_null = (y.rec.next_station_code == NULL_CODE);
        if (!x.valid) begin
            res = 1'b0;
        end else if (!y.valid) begin
            res = 1'b1;
        end else if (key == 1'(KEY_STATION)) begin
            res = (x.rec.station_code < y.rec.station_code);
        end else if (x_null || y_null) begin
            res = !x_null && y_null;
        end else begin
            res = (x.rec.next_station_code < y.rec.next_station_code);
        end
        return res;
    endfunction

endpackage

// ----- src/rsk_cell.sv -----
module rsk_cell (
    input  logic               aclk,
    input  logic               aresetn,
    input  rsk_pkg::cell_ctrl_t ctrl,
    input  rsk_pkg::cell_t     up,
    input  rsk_pkg::cell_t     down,
    output rsk_pkg::cell_t     cur
);
    import rsk_pkg::*;

    logic  valid_reg;
    logic  valid_next;
    rec_t  rec_reg;
    rec_t  rec_next;
    cell_t self;
    cell_t pick;

    assign self.valid = valid_reg;
    assign self.rec   = rec_reg;
    assign cur        = self;

    always_comb begin
        pick = self;
        if (ctrl.shift) begin
            pick = up;
        end else if (ctrl.lo_en && goes_before(up, self, ctrl.key)) begin
            pick = up;
        end else if (ctrl.hi_en && goes_before(self, down, ctrl.key)) begin
            pick = down;
        end
        valid_next = pick.valid;
        rec_next   = pick.rec;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
        rec_reg <= rec_next;
    end

endmodule

// ----- src/record_sort_by_key_nulls_last.sv -----
// Record sorter. Records arrive on the s_ channel, one transfer per cycle while
// s_tready is high. Records flagged removed in s_tuser are dropped; the others
// enter a row of CAPACITY cells in arrival order. Kept records beyond CAPACITY
// are dropped and the overflow flag is raised for the set.
// The transfer with s_tlast closes the set and samples key_select (station code,
// or next-station code with nulls last). The cell row then runs alternating
// odd/even neighbor compare-exchange, which orders the set stably; s_tready is
// low during that time and during emission.
// The sorted records then leave on the m_ channel at one per cycle while
// m_tready is high; every result carries the kept count and the overflow
// flag, and m_tlast marks the final one. An empty set gives one result with
// record_present low.
// The output register holds a result for as long as m_tready stays low, and the
// row simply waits. After the final result is registered the block accepts
// the next set while that result is still waiting.
// Reset empties the cells, clears the count and the overflow flag and sets
// key_select to zero. The cfg channel is always ready.
module record_sort_by_key_nulls_last (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [0:0]  cfg_data,      // key_select
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [71:0] s_tdata,       // station_code, next_station_code, record_tag, zero pad
    input  logic [0:0]  s_tuser,       // removed
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [71:0] m_tdata,       // out_station_code, out_next_station_code, out_tag,
                                       // valid_count
    output logic [1:0]  m_tuser,       // record_present, overflowed
    output logic        m_tlast
);
    import rsk_pkg::*;

    typedef enum logic [1:0] {
        S_LOAD,
        S_SORT,
        S_EMIT
    } state_t;

    state_t            state_reg, state_next;
    logic              key_select_reg, key_select_next;
    logic              sort_key_reg, sort_key_next;
    logic [CNT_W-1:0]  kept_count_reg, kept_count_next;
    logic              overflow_reg, overflow_next;
    logic [SORT_W-1:0] sort_cnt_reg, sort_cnt_next;
    logic [CNT_W-1:0]  emit_left_reg, emit_left_next;
    logic              m_tvalid_reg, m_tvalid_next;
    logic [71:0]       m_tdata_reg, m_tdata_next;
    logic [1:0]        m_tuser_reg, m_tuser_next;
    logic              m_tlast_reg, m_tlast_next;

    cell_t             cells [CAPACITY];
    cell_ctrl_t        ctrls [CAPACITY];
    logic [CAPACITY-1:0] valid_vec;
    cell_t             top_feed;
    cell_t             in_cell;

    logic s_fire;
    logic slot_free;
    logic do_load;
    logic do_emit_shift;
    logic sorting;
    logic phase;

    assign cfg_ready = 1'b1;
    assign s_tready  = (state_reg == S_LOAD);
    assign s_fire    = s_tvalid && s_tready;
    assign slot_free = !m_tvalid_reg || m_tready;

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;
    assign m_tlast  = m_tlast_reg;

    assign in_cell.valid                 = 1'b1;
    assign in_cell.rec.station_code      = s_tdata[15:0];
    assign in_cell.rec.next_station_code = $signed(s_tdata[32:16]);
    assign in_cell.rec.record_tag        = s_tdata[64:33];

    assign do_load = s_fire && !s_tuser[0]
                     && (kept_count_reg < CNT_W'(CAPACITY));
    assign do_emit_shift = (state_reg == S_EMIT) && slot_free
                           && (kept_count_reg != '0);
    assign sorting  = (state_reg == S_SORT);
    assign phase    = sort_cnt_reg[0];
    assign top_feed = do_load ? in_cell : EMPTY_CELL;

    for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
        cell_t up_i;
        cell_t down_i;
        if (i == CAPACITY - 1) begin : g_top
            assign up_i = top_feed;
        end else begin : g_mid
            assign up_i = cells[i+1];
        end
        if (i == 0) begin : g_bot
            assign down_i = EMPTY_CELL;
        end else begin : g_low
            assign down_i = cells[i-1];
        end

        assign ctrls[i].shift = do_load || do_emit_shift;
        assign ctrls[i].lo_en = sorting && (1'(i % 2) == phase) && (i < CAPACITY - 1);
        assign ctrls[i].hi_en = sorting && (1'(i % 2) != phase) && (i > 0);
        assign ctrls[i].key   = sort_key_reg;
        assign valid_vec[i]   = cells[i].valid;

        rsk_cell u_cell (
            .aclk    (aclk),
            .aresetn (aresetn),
            .ctrl    (ctrls[i]),
            .up      (up_i),
            .down    (down_i),
            .cur     (cells[i])
        );
    end

    always_comb begin
        state_next      = state_reg;
        key_select_next = key_select_reg;
        sort_key_next   = sort_key_reg;
        kept_count_next = kept_count_reg;
        overflow_next   = overflow_reg;
        sort_cnt_next   = sort_cnt_reg;
        emit_left_next  = emit_left_reg;
        m_tvalid_next   = m_tvalid_reg;
        m_tdata_next    = m_tdata_reg;
        m_tuser_next    = m_tuser_reg;
        m_tlast_next    = m_tlast_reg;

        if (cfg_valid && cfg_ready) begin
            key_select_next = cfg_data[0];
        end
        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end

        case (state_reg)
            S_LOAD: begin
                if (s_fire) begin
                    if (do_load) begin
                        kept_count_next = kept_count_reg + 1'b1;
                    end else if (!s_tuser[0]) begin
                        overflow_next = 1'b1;
                    end
                    if (s_tlast) begin
                        sort_key_next = key_select_reg;
                        sort_cnt_next = '0;
                        if (kept_count_next == '0) begin
                            state_next = S_EMIT;
                        end else begin
                            state_next = S_SORT;
                        end
                    end
                end
            end
            S_SORT: begin
                sort_cnt_next = sort_cnt_reg + 1'b1;
                if (sort_cnt_reg == SORT_W'(CAPACITY - 1)) begin
                    emit_left_next = kept_count_reg;
                    state_next     = S_EMIT;
                end
            end
            S_EMIT: begin
                if (slot_free) begin
                    m_tvalid_next = 1'b1;
                    if (kept_count_reg == '0) begin
                        m_tdata_next    = '0;
                        m_tuser_next    = {overflow_reg, 1'b0};
                        m_tlast_next    = 1'b1;
                        overflow_next   = 1'b0;
                        state_next      = S_LOAD;
                    end else begin
                        m_tdata_next = {kept_count_reg, cells[0].rec.record_tag,
                                        cells[0].rec.next_station_code,
                                        cells[0].rec.station_code};
                        m_tuser_next   = {overflow_reg, 1'b1};
                        m_tlast_next   = (emit_left_reg == CNT_W'(1));
                        emit_left_next = emit_left_reg - 1'b1;
                        if (emit_left_reg == CNT_W'(1)) begin
                            kept_count_next = '0;
                            overflow_next   = 1'b0;
                            state_next      = S_LOAD;
                        end
                    end
                end
            end
            default: begin
                state_next = S_LOAD;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_LOAD;
            key_select_reg <= 1'b0;
            sort_key_reg   <= 1'b0;
            kept_count_reg <= '0;
            overflow_reg   <= 1'b0;
            sort_cnt_reg   <= '0;
            emit_left_reg  <= '0;
            m_tvalid_reg   <= 1'b0;
        end else begin
            state_reg      <= state_next;
            key_select_reg <= key_select_next;
            sort_key_reg   <= sort_key_next;
            kept_count_reg <= kept_count_next;
            overflow_reg   <= overflow_next;
            sort_cnt_reg   <= sort_cnt_next;
            emit_left_reg  <= emit_left_next;
            m_tvalid_reg   <= m_tvalid_next;
        end
        m_tdata_reg <= m_tdata_next;
        m_tuser_reg <= m_tuser_next;
        m_tlast_reg <= m_tlast_next;
    end

`ifndef SYNTHESIS
    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        kept_count_reg <= CNT_W'(CAPACITY))
        else $error("kept count exceeds capacity");

    a_count_matches_cells: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == S_LOAD |-> $countones(valid_vec) == int'(kept_count_reg))
        else $error("occupied cells disagree with kept count");

    a_emit_from_bottom: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_EMIT && emit_left_reg != '0) |-> valid_vec[0])
        else $error("emission reads an empty bottom cell");

    a_sort_keeps_count: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == S_SORT |=> $countones(valid_vec) == int'(kept_count_reg))
        else $error("sorting changed the number of records");
`endif

endmodule
